// ===== design/rotating_sprite_multiplexer_core_assert.svh =====
// Assertion macros for the sprite multiplexer checker.
// Standalone header; no dependencies.
`ifndef ROTATING_SPRITE_MULTIPLEXER_CORE_ASSERT_SVH
`define ROTATING_SPRITE_MULTIPLEXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsm: next-cycle check failed");

`endif

// ===== design/rsm_pkg.sv =====
// Shared types, constants and the colour row table of the sprite multiplexer.
// No dependencies.
`default_nettype none

package rsm_pkg;

    // Register reset values and fixed limits
    localparam logic [7:0] DISABLED_LINE_RST = 8'd216;
    localparam logic [4:0] SCAN_STRIDE_RST   = 5'd7;
    localparam logic [4:0] FRAME_ADVANCE_RST = 5'd19;
    localparam logic [5:0] PLANE_BUDGET_RST  = 6'd32;
    localparam logic [5:0] MAX_PLANES        = 6'd32;
    localparam logic [7:0] HIDDEN_Y          = 8'd216;   // y of every entry after reset
    localparam int         COLOUR_CODES      = 7;
    localparam int         IDX_W             = 6;        // wide enough for 64 entries
    localparam int         RAW_INDEX_VALUES  = 32;       // codes of a 5-bit index field

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    typedef enum logic [1:0] {
        REG_DISABLED_LINE = 2'd0,
        REG_SCAN_STRIDE   = 2'd1,
        REG_FRAME_ADVANCE = 2'd2,
        REG_PLANE_BUDGET  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] disabled_line;
        logic [4:0] scan_stride;
        logic [4:0] frame_advance;
        logic [5:0] plane_budget;
    } t_cfg;

    typedef struct packed {
        logic       mode;
        logic [4:0] entry_index;
        logic [7:0] pos_y;
        logic [7:0] pos_x;
        logic [7:0] first_pattern;
        logic [2:0] first_colour;
        logic [1:0] plane_count;
        logic [7:0] second_pattern;
        logic [2:0] second_colour;
    } t_in_item;

    typedef struct packed {
        logic        plane_valid;
        logic [4:0]  plane_slot;
        logic [7:0]  out_y;
        logic [7:0]  out_x;
        logic [7:0]  out_pattern;
        logic [2:0]  out_colour_code;
        logic [63:0] colour_rows_low;
        logic [63:0] colour_rows_high;
        logic        last_plane;
    } t_out_item;

    // One virtual sprite as held in the table
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] pat0;
        logic [2:0] col0;
        logic       two;      // sprite uses two planes
        logic [7:0] pat1;
        logic [2:0] col1;
    } t_entry;

    // Classified request handed from front to back
    typedef struct packed {
        logic             frame;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] stride;
        logic [IDX_W-1:0] advance;
        logic [5:0]       budget;
        t_entry           entry;
    } t_cmd;

    // 16 colour bytes of a code, row 0 in the low byte; {rows 15..8, rows 7..0}
    function automatic logic [127:0] colour_rows(input logic [2:0] code);
        logic [127:0] rows;
        rows = '0;
        case (code)
            3'd0:    rows = {16{8'h02}};
            3'd1:    rows = {16{8'h04}};
            3'd2:    rows = {16{8'h08}};
            3'd3:    rows = {16{8'h0A}};
            3'd4:    rows = {16{8'h41}};
            3'd5:    rows = {64'h0404040404040504, 64'h0505050507070504};
            3'd6:    rows = {64'h0C0C0C0C0C0C020C, 64'h020202020303020C};
            default: rows = '0;
        endcase
        if (int'(code) >= COLOUR_CODES) begin
            rows = '0;
        end
        return rows;
    endfunction

endpackage

`default_nettype wire

// ===== design/rotating_sprite_multiplexer_core.sv =====
// Rotating-priority sprite multiplexer: top level with configuration registers.
// Depends on rsm_pkg, rsm_front, rsm_fifo and rsm_back.
//
//   channel   direction  handshake                      payload
//   input     in         i_in_valid / o_in_stall        i_in_item  (rsm_pkg::t_in_item)
//   output    out        o_out_valid / i_out_stall      o_out_item (rsm_pkg::t_out_item)
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A table write is taken by the back end while idle. A frame is dispatched, then the
// scan visits at most TABLE_ENTRIES entries plus the second planes of two-plane sprites,
// then closes (end of scan seen, final result); the scan walks the single table read port.
// Reset is synchronous and active low; the table reads as hidden until written.
// A held output stalls the scan only when a new result needs the output register;
// the two-entry request queue keeps the input side open while a frame runs.
`default_nettype none

module rotating_sprite_multiplexer_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // request input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rsm_pkg::t_in_item  i_in_item,
    // result output
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rsm_pkg::t_out_item      o_out_item
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CMD_W = $bits(rsm_pkg::t_cmd);

    rsm_pkg::t_cfg     r_cfg;
    rsm_pkg::t_reg_idx w_reg;
    rsm_pkg::t_cmd     w_front_cmd;
    rsm_pkg::t_cmd     w_back_cmd;
    logic              w_cmd_valid;
    logic              w_cmd_stall;
    logic              w_cfg_wr;

    // ---------------------------------------------------------------
    // Configuration registers, 4 bytes apart; the block does not enforce it, but they are to be written only while idle
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_reg    = rsm_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disabled_line <= rsm_pkg::DISABLED_LINE_RST;
            r_cfg.scan_stride   <= rsm_pkg::SCAN_STRIDE_RST;
            r_cfg.frame_advance <= rsm_pkg::FRAME_ADVANCE_RST;
            r_cfg.plane_budget  <= rsm_pkg::PLANE_BUDGET_RST;
        end else if (w_cfg_wr) begin
            case (w_reg)
                rsm_pkg::REG_DISABLED_LINE: r_cfg.disabled_line <= pwdata[7:0];
                rsm_pkg::REG_SCAN_STRIDE:   r_cfg.scan_stride   <= pwdata[4:0];
                rsm_pkg::REG_FRAME_ADVANCE: r_cfg.frame_advance <= pwdata[4:0];
                rsm_pkg::REG_PLANE_BUDGET:  r_cfg.plane_budget  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            rsm_pkg::REG_DISABLED_LINE: prdata = 32'(r_cfg.disabled_line);
            rsm_pkg::REG_SCAN_STRIDE:   prdata = 32'(r_cfg.scan_stride);
            rsm_pkg::REG_FRAME_ADVANCE: prdata = 32'(r_cfg.frame_advance);
            rsm_pkg::REG_PLANE_BUDGET:  prdata = 32'(r_cfg.plane_budget);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front: reduce indexes mod table size, snapshot frame settings
    // ---------------------------------------------------------------
    rsm_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_front (
        .i_item (i_in_item),
        .i_cfg  (r_cfg),
        .o_cmd  (w_front_cmd)
    );

    // Request queue: writes and frames stay in order
    rsm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_in_valid),
        .o_wr_stall (o_in_stall),
        .i_wr_data  (w_front_cmd),
        .o_rd_valid (w_cmd_valid),
        .i_rd_stall (w_cmd_stall),
        .o_rd_data  (w_back_cmd)
    );

    // ---------------------------------------------------------------
    // Back: table, scan and output register
    // ---------------------------------------------------------------
    rsm_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_stall     (w_cmd_stall),
        .i_cmd           (w_back_cmd),
        .i_disabled_line (r_cfg.disabled_line),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_item      (o_out_item)
    );

endmodule

`default_nettype wire

// ===== design/rsm_fifo.sv =====
// Small request queue between the front and back of the sprite multiplexer.
// Generic width and depth; no package dependency.
`default_nettype none

module rsm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_valid,
    output logic                  o_wr_stall,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_stall,
    output logic      [WIDTH-1:0] o_rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_push, w_pop;

    assign o_wr_stall = (r_count == CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && !o_wr_stall;
    assign w_pop      = o_rd_valid && !i_rd_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/rsm_front.sv =====
// Front end: classifies an input item into a table write or a frame request.
// Depends on rsm_pkg.
`default_nettype none

module rsm_front #(
    parameter int TABLE_ENTRIES = 32,
    parameter int IW            = 5
) (
    input  wire rsm_pkg::t_in_item i_item,
    input  wire rsm_pkg::t_cfg     i_cfg,
    output rsm_pkg::t_cmd          o_cmd
);

    localparam int CW = rsm_pkg::IDX_W;

    // value mod TABLE_ENTRIES for every 5-bit code
    logic [IW-1:0] w_mod_lut [rsm_pkg::RAW_INDEX_VALUES];

    for (genvar gv = 0; gv < rsm_pkg::RAW_INDEX_VALUES; gv++) begin : g_mod_lut
        assign w_mod_lut[gv] = IW'(gv % TABLE_ENTRIES);
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.frame   = (i_item.mode == rsm_pkg::MODE_FRAME);
        o_cmd.index   = CW'(w_mod_lut[i_item.entry_index]);
        o_cmd.stride  = CW'(w_mod_lut[i_cfg.scan_stride]);
        o_cmd.advance = CW'(w_mod_lut[i_cfg.frame_advance]);
        o_cmd.budget  = (i_cfg.plane_budget > rsm_pkg::MAX_PLANES) ?
                        rsm_pkg::MAX_PLANES : i_cfg.plane_budget;
        o_cmd.entry.y    = i_item.pos_y;
        o_cmd.entry.x    = i_item.pos_x;
        o_cmd.entry.pat0 = i_item.first_pattern;
        o_cmd.entry.col0 = i_item.first_colour;
        o_cmd.entry.two  = i_item.plane_count[1];   // codes 2 and 3
        o_cmd.entry.pat1 = i_item.second_pattern;
        o_cmd.entry.col1 = i_item.second_colour;
    end

endmodule

`default_nettype wire

// ===== design/rsm_back.sv =====
// Back end: sprite table, rotating scan and result output register.
// Depends on rsm_pkg.
`default_nettype none

module rsm_back #(
    parameter int TABLE_ENTRIES = 32,
    parameter int IW            = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_stall,
    input  wire rsm_pkg::t_cmd     i_cmd,
    input  wire logic [7:0]        i_disabled_line,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output rsm_pkg::t_out_item     o_out_item
);

    localparam int VW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic [4:0] slot;
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] pattern;
        logic [2:0] code;
    } t_plane;

    t_state            r_state, n_state;
    rsm_pkg::t_entry   r_table [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld, n_vld;
    logic [IW-1:0]     r_scan_start, n_scan_start;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_stride, n_stride;
    logic [IW-1:0]     r_adv, n_adv;
    logic [5:0]        r_remain, n_remain;
    logic [VW-1:0]     r_visits, n_visits;
    logic [4:0]        r_slot, n_slot;
    logic              r_second, n_second;
    logic              r_hold_valid, n_hold_valid;
    t_plane            r_hold, n_hold;
    logic              r_out_valid, n_out_valid;
    rsm_pkg::t_out_item r_out, n_out;

    rsm_pkg::t_entry   w_ent;
    logic              w_out_free, w_can_put, w_visible, w_fits, w_scan_end;
    logic [IW:0]       w_idx_sum, w_start_sum;
    logic [IW-1:0]     w_next_idx, w_next_start;
    logic              w_tbl_we;
    logic [IW-1:0]     w_tbl_idx;
    t_plane            w_plane;

    function automatic rsm_pkg::t_out_item plane_result(input t_plane p, input logic last);
        rsm_pkg::t_out_item o;
        logic [127:0]       rows;
        rows              = rsm_pkg::colour_rows(p.code);
        o.plane_valid     = 1'b1;
        o.plane_slot      = p.slot;
        o.out_y           = p.y;
        o.out_x           = p.x;
        o.out_pattern     = p.pattern;
        o.out_colour_code = p.code;
        o.colour_rows_low = rows[63:0];
        o.colour_rows_high = rows[127:64];
        o.last_plane      = last;
        return o;
    endfunction

    // entry at the scan pointer; never-written entries read as hidden
    always_comb begin
        w_ent = '0;
        w_ent.y = rsm_pkg::HIDDEN_Y;
        if (r_vld[r_idx]) begin
            w_ent = r_table[r_idx];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_can_put  = !r_hold_valid || w_out_free;
    assign w_visible  = (w_ent.y != i_disabled_line);
    assign w_fits     = w_ent.two ? (r_remain >= 6'd2) : (r_remain != '0);
    assign w_scan_end = (r_visits == VW'(TABLE_ENTRIES)) || (r_remain == '0);

    assign w_idx_sum    = {1'b0, r_idx} + {1'b0, r_stride};
    assign w_next_idx   = (w_idx_sum >= (IW+1)'(TABLE_ENTRIES)) ?
                          IW'(w_idx_sum - (IW+1)'(TABLE_ENTRIES)) : w_idx_sum[IW-1:0];
    assign w_start_sum  = {1'b0, r_scan_start} + {1'b0, r_adv};
    assign w_next_start = (w_start_sum >= (IW+1)'(TABLE_ENTRIES)) ?
                          IW'(w_start_sum - (IW+1)'(TABLE_ENTRIES)) : w_start_sum[IW-1:0];

    assign o_cmd_stall = (r_state != ST_IDLE);
    assign w_tbl_idx   = i_cmd.index[IW-1:0];
    assign w_tbl_we    = (r_state == ST_IDLE) && i_cmd_valid && !i_cmd.frame;

    always_comb begin
        w_plane.slot    = r_slot;
        w_plane.y       = w_ent.y;
        w_plane.x       = w_ent.x;
        w_plane.pattern = r_second ? w_ent.pat1 : w_ent.pat0;
        w_plane.code    = r_second ? w_ent.col1 : w_ent.col0;
    end

    always_comb begin
        n_state      = r_state;
        n_vld        = r_vld;
        n_scan_start = r_scan_start;
        n_idx        = r_idx;
        n_stride     = r_stride;
        n_adv        = r_adv;
        n_remain     = r_remain;
        n_visits     = r_visits;
        n_slot       = r_slot;
        n_second     = r_second;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.frame) begin
                        n_idx        = r_scan_start;
                        n_stride     = i_cmd.stride[IW-1:0];
                        n_adv        = i_cmd.advance[IW-1:0];
                        n_remain     = i_cmd.budget;
                        n_visits     = '0;
                        n_slot       = '0;
                        n_second     = 1'b0;
                        n_hold_valid = 1'b0;
                        n_state      = ST_SCAN;
                    end else begin
                        n_vld[w_tbl_idx] = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_second || (!w_scan_end && w_visible && w_fits)) begin
                    // a plane is due; it waits in the hold stage until the next
                    // one or the end of the scan tells whether it is the last
                    if (w_can_put) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = plane_result(r_hold, 1'b0);
                        end
                        n_hold       = w_plane;
                        n_hold_valid = 1'b1;
                        n_slot       = r_slot + 1'b1;
                        n_remain     = r_remain - 1'b1;
                        if (!r_second && w_ent.two) begin
                            n_second = 1'b1;
                        end else begin
                            n_second = 1'b0;
                            n_idx    = w_next_idx;
                            n_visits = r_visits + 1'b1;
                        end
                    end
                end else if (w_scan_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx    = w_next_idx;
                    n_visits = r_visits + 1'b1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_hold_valid) begin
                        n_out = plane_result(r_hold, 1'b1);
                    end else begin
                        n_out            = '0;
                        n_out.last_plane = 1'b1;
                    end
                    n_hold_valid = 1'b0;
                    n_scan_start = w_next_start;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_vld        <= '0;
            r_scan_start <= '0;
            r_second     <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_vld        <= n_vld;
            r_scan_start <= n_scan_start;
            r_second     <= n_second;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_stride <= n_stride;
        r_adv    <= n_adv;
        r_remain <= n_remain;
        r_visits <= n_visits;
        r_slot   <= n_slot;
        r_hold   <= n_hold;
        r_out    <= n_out;
        if (w_tbl_we) begin
            r_table[w_tbl_idx] <= i_cmd.entry;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== design/rsm_checker.sv =====
// Port-level checker for the sprite multiplexer, bound to the top level.
// Depends on rsm_pkg and rotating_sprite_multiplexer_core_assert.svh.
`default_nettype none

`include "rotating_sprite_multiplexer_core_assert.svh"

module rsm_port_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire rsm_pkg::t_out_item o_out_item
);

    logic [4:0] r_exp_slot;
    logic       w_out_acc;
    logic       w_plane_out, w_slot_ok;
    logic       w_empty_out, w_empty_ok;
    logic       w_bad_code, w_rows_zero;
    logic       w_out_held;

    assign w_out_acc = o_out_valid && !i_out_stall;

    // slot expected next: restarts after each frame's final result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_slot <= '0;
        end else if (w_out_acc) begin
            r_exp_slot <= o_out_item.last_plane ? 5'd0 : o_out_item.plane_slot + 1'b1;
        end
    end

    assign w_plane_out = o_out_valid && o_out_item.plane_valid;
    assign w_slot_ok   = (o_out_item.plane_slot == r_exp_slot);
    assign w_empty_out = o_out_valid && !o_out_item.plane_valid;
    assign w_empty_ok  = o_out_item.last_plane && (r_exp_slot == 5'd0) &&
                         (o_out_item.plane_slot == 5'd0);
    assign w_bad_code  = o_out_valid &&
                         (int'(o_out_item.out_colour_code) >= rsm_pkg::COLOUR_CODES);
    assign w_rows_zero = (o_out_item.colour_rows_low == 64'd0) &&
                         (o_out_item.colour_rows_high == 64'd0);
    assign w_out_held  = o_out_valid && i_out_stall;

    `RSM_ASSERT_IMP(a_slot_order, i_clk, i_rst_n, w_plane_out, w_slot_ok)
    `RSM_ASSERT_IMP(a_empty_frame, i_clk, i_rst_n, w_empty_out, w_empty_ok)
    `RSM_ASSERT_IMP(a_no_colour_row, i_clk, i_rst_n, w_bad_code, w_rows_zero)
    `RSM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_held, o_out_valid && $stable(o_out_item))

endmodule

bind rotating_sprite_multiplexer_core rsm_port_checker u_rsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== bench/rsm_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the sprite multiplexer: follows register writes and table loads,
// works out the planes of every frame request and checks results in order.
// Depends on rsm_pkg.

module rsm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  rsm_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  rsm_pkg::t_out_item i_out_item,
    output int                 o_errors,
    output int                 o_pending
);
    import rsm_pkg::*;

    localparam int ENTRIES   = 32;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] pat_a;
        logic [2:0] col_a;
        logic [1:0] planes;
        logic [7:0] pat_b;
        logic [2:0] col_b;
    } sprite_t;

    sprite_t    sprites [ENTRIES];
    logic [4:0] scan_head;
    logic [7:0] hide_line;
    logic [4:0] step;
    logic [4:0] head_advance;
    logic [5:0] budget;
    t_out_item  planes_due [$];
    int         fail_count = 0;
    int         pending_count = 0;
    int         k;

    assign o_errors  = fail_count;
    assign o_pending = pending_count;

    // Colour byte of one row; codes 5 and 6 share the same row shape.
    function automatic logic [7:0] shade_byte(input logic [2:0] code, input int row);
        logic [7:0] b;
        logic       odd_code;
        b = 8'h00;
        odd_code = (code == 3'd5);
        case (code)
            3'd0: b = 8'h02;
            3'd1: b = 8'h04;
            3'd2: b = 8'h08;
            3'd3: b = 8'h0A;
            3'd4: b = 8'h41;
            3'd5, 3'd6: begin
                if (row == 2 || row == 3)
                    b = odd_code ? 8'h07 : 8'h03;
                else if (row == 1 || row == 9 || (row >= 4 && row <= 7))
                    b = odd_code ? 8'h05 : 8'h02;
                else
                    b = odd_code ? 8'h04 : 8'h0C;
            end
            default: b = 8'h00;
        endcase
        if (int'(code) >= COLOUR_CODES) b = 8'h00;
        return b;
    endfunction

    function automatic t_out_item plane_of(input int slot, input sprite_t s,
                                           input logic [7:0] pat, input logic [2:0] col);
        t_out_item p;
        int        r;
        p = '0;
        p.plane_valid     = 1'b1;
        p.plane_slot      = slot[4:0];
        p.out_y           = s.y;
        p.out_x           = s.x;
        p.out_pattern     = pat;
        p.out_colour_code = col;
        for (r = 0; r < 8; r++) begin
            p.colour_rows_low[8*r +: 8]  = shade_byte(col, r);
            p.colour_rows_high[8*r +: 8] = shade_byte(col, r + 8);
        end
        return p;
    endfunction

    // Walk the table from the rotating head and queue the planes it yields.
    task automatic run_frame();
        t_out_item  batch [ENTRIES];
        sprite_t    s;
        logic [4:0] at;
        logic       pair;
        int         left;
        int         made;
        int         n;
        left = (budget > MAX_PLANES) ? int'(MAX_PLANES) : int'(budget);
        made = 0;
        at   = scan_head;
        for (n = 0; n < ENTRIES && left > 0; n++) begin
            s    = sprites[at];
            pair = (s.planes >= 2'd2);
            if (s.y != hide_line && (pair ? 2 : 1) <= left) begin
                batch[made] = plane_of(made, s, s.pat_a, s.col_a);
                made++;
                left--;
                if (pair) begin
                    batch[made] = plane_of(made, s, s.pat_b, s.col_b);
                    made++;
                    left--;
                end
            end
            at = at + step;
        end
        scan_head = scan_head + head_advance;
        if (made == 0) begin
            batch[0] = '0;
            batch[0].last_plane = 1'b1;
            made = 1;
        end else begin
            batch[made-1].last_plane = 1'b1;
        end
        for (n = 0; n < made; n++) planes_due.push_back(batch[n]);
    endtask

    task automatic check_plane(input t_out_item got);
        t_out_item want;
        if (planes_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display("checker: plane with none due: v%0b slot %0d y %02h x %02h last %0b",
                         got.plane_valid, got.plane_slot, got.out_y, got.out_x,
                         got.last_plane);
        end else begin
            want = planes_due.pop_front();
            if (got.plane_valid !== want.plane_valid || got.plane_slot !== want.plane_slot ||
                got.out_y !== want.out_y || got.out_x !== want.out_x ||
                got.out_pattern !== want.out_pattern ||
                got.out_colour_code !== want.out_colour_code ||
                got.colour_rows_low !== want.colour_rows_low ||
                got.colour_rows_high !== want.colour_rows_high ||
                got.last_plane !== want.last_plane) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display("checker: plane mismatch");
                    $display("  exp v%0b slot %0d y %02h x %02h pat %02h code %0d %h_%h last %0b",
                             want.plane_valid, want.plane_slot, want.out_y, want.out_x,
                             want.out_pattern, want.out_colour_code, want.colour_rows_high,
                             want.colour_rows_low, want.last_plane);
                    $display("  got v%0b slot %0d y %02h x %02h pat %02h code %0d %h_%h last %0b",
                             got.plane_valid, got.plane_slot, got.out_y, got.out_x,
                             got.out_pattern, got.out_colour_code, got.colour_rows_high,
                             got.colour_rows_low, got.last_plane);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (k = 0; k < ENTRIES; k++) begin
                sprites[k]   = '0;
                sprites[k].y = HIDDEN_Y;
            end
            scan_head    = '0;
            hide_line    = DISABLED_LINE_RST;
            step         = SCAN_STRIDE_RST;
            head_advance = FRAME_ADVANCE_RST;
            budget       = PLANE_BUDGET_RST;
            planes_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_DISABLED_LINE: hide_line    = i_pwdata[7:0];
                    REG_SCAN_STRIDE:   step         = i_pwdata[4:0];
                    REG_FRAME_ADVANCE: head_advance = i_pwdata[4:0];
                    REG_PLANE_BUDGET:  budget       = i_pwdata[5:0];
                    default: ;
                endcase
            end
            // results first: none can stem from a request taken at this same edge
            if (i_out_valid && !i_out_stall) check_plane(i_out_item);
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.mode == MODE_FRAME) begin
                    run_frame();
                end else begin
                    sprites[i_in_item.entry_index].y      = i_in_item.pos_y;
                    sprites[i_in_item.entry_index].x      = i_in_item.pos_x;
                    sprites[i_in_item.entry_index].pat_a  = i_in_item.first_pattern;
                    sprites[i_in_item.entry_index].col_a  = i_in_item.first_colour;
                    sprites[i_in_item.entry_index].planes = i_in_item.plane_count;
                    sprites[i_in_item.entry_index].pat_b  = i_in_item.second_pattern;
                    sprites[i_in_item.entry_index].col_b  = i_in_item.second_colour;
                end
            end
        end
        pending_count = planes_due.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Bench top for the sprite multiplexer: clock, reset, register writes and request /
// result traffic with random idling. Depends on rsm_pkg, rsm_checker and the block.

module tb;

    localparam int SETTLE_CYCLES = 100;        // well above the longest frame and queued loads
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int HOLD_CYCLES   = 300;        // long output hold-off, fills the block
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 42;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [3:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    rsm_pkg::t_in_item  i_in_item  = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    rsm_pkg::t_out_item o_out_item;

    int          fail_total;
    int          planes_waiting;
    int          cycle_count    = 0;
    bit          sender_quiet   = 1'b0;   // no gaps between requests
    bit          receiver_quiet = 1'b0;   // result side never stalls
    bit          hold_req       = 1'b0;   // ask the result side for one long hold-off
    logic [7:0]  line_now       = rsm_pkg::DISABLED_LINE_RST;

    rotating_sprite_multiplexer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    rsm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .o_errors    (fail_total),
        .o_pending   (planes_waiting)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Result side. Runs of stall / no stall, mostly short, now and then long.
    // One request for a long hold-off is served here, counted in its own cycles,
    // while the request side keeps offering so the block backs up.
    initial begin : result_side
        int run;
        int pick;
        bit hold;
        bit held;
        held = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_req && !held) begin
                held = 1'b1;
                hold = 1'b1;
                run  = HOLD_CYCLES;
            end else if (receiver_quiet || pick < 55) begin
                hold = 1'b0;
                run  = receiver_quiet ? 1 : $urandom_range(1, 30);
            end else if (pick < 92) begin
                hold = 1'b1;
                run  = $urandom_range(1, 3);
            end else begin
                hold = 1'b1;
                run  = $urandom_range(10, 60);
            end
            @(negedge i_clk);
            i_out_stall <= hold;
            repeat (run - 1) @(negedge i_clk);
        end
    end

    // Offer one request after a random gap and hold it until taken.
    task automatic send_request(input rsm_pkg::t_in_item req);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_quiet || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Setup cycle, then access cycle; the register takes the value when pready is seen.
    task automatic write_reg(input rsm_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, wait for every due plane, then let trailing table loads finish.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (planes_waiting != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] line, input logic [4:0] stride,
                            input logic [4:0] adv, input logic [5:0] budget);
        settle();
        write_reg(rsm_pkg::REG_DISABLED_LINE, {24'd0, line});
        write_reg(rsm_pkg::REG_SCAN_STRIDE,   {27'd0, stride});
        write_reg(rsm_pkg::REG_FRAME_ADVANCE, {27'd0, adv});
        write_reg(rsm_pkg::REG_PLANE_BUDGET,  {26'd0, budget});
        line_now = line;
    endtask

    function automatic rsm_pkg::t_in_item load_item(
        input logic [4:0] idx, input logic [7:0] y,
        input logic [7:0] x, input logic [7:0] p0,
        input logic [2:0] c0, input logic [1:0] cnt,
        input logic [7:0] p1, input logic [2:0] c1);
        rsm_pkg::t_in_item r;
        r.mode           = rsm_pkg::MODE_WRITE;
        r.entry_index    = idx;
        r.pos_y          = y;
        r.pos_x          = x;
        r.first_pattern  = p0;
        r.first_colour   = c0;
        r.plane_count    = cnt;
        r.second_pattern = p1;
        r.second_colour  = c1;
        return r;
    endfunction

    // Frame request; the other fields carry noise the block must ignore.
    function automatic rsm_pkg::t_in_item frame_item();
        rsm_pkg::t_in_item r;
        logic [63:0]       bits;
        bits   = {$urandom, $urandom};
        r      = bits[$bits(rsm_pkg::t_in_item)-1:0];
        r.mode = rsm_pkg::MODE_FRAME;
        return r;
    endfunction

    // Random table load; some land on the current hidden line.
    function automatic rsm_pkg::t_in_item random_load();
        rsm_pkg::t_in_item r;
        logic [63:0]       bits;
        bits   = {$urandom, $urandom};
        r      = bits[$bits(rsm_pkg::t_in_item)-1:0];
        r.mode = rsm_pkg::MODE_WRITE;
        if ($urandom_range(0, 99) < 15) r.pos_y = line_now;
        return r;
    endfunction

    initial begin : stimulus
        int ph;
        int n;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Table straight out of reset: every entry hidden, so an empty frame.
        send_request(frame_item());
        // Field extremes and all eight colour codes across both planes.
        send_request(load_item(5'd0,  8'd0,   8'd255, 8'hFF, 3'd7, 2'd0, 8'h00, 3'd0));
        send_request(load_item(5'd31, 8'd255, 8'd0,   8'h00, 3'd6, 2'd3, 8'hFF, 3'd5));
        send_request(load_item(5'd7,  8'd100, 8'd50,  8'h01, 3'd0, 2'd2, 8'h02, 3'd1));
        send_request(load_item(5'd14, 8'd216, 8'd5,   8'h11, 3'd2, 2'd1, 8'h22, 3'd3));
        send_request(load_item(5'd21, 8'd10,  8'd20,  8'h03, 3'd3, 2'd2, 8'h04, 3'd4));
        send_request(load_item(5'd28, 8'd30,  8'd40,  8'h05, 3'd2, 2'd1, 8'hAA, 3'd6));
        send_request(frame_item());
        send_request(frame_item());
        // Budget of one: two-plane sprites no longer fit.
        set_regs(rsm_pkg::DISABLED_LINE_RST, rsm_pkg::SCAN_STRIDE_RST,
                 rsm_pkg::FRAME_ADVANCE_RST, 6'd1);
        send_request(frame_item());
        // Zero budget gives an empty frame.
        set_regs(rsm_pkg::DISABLED_LINE_RST, rsm_pkg::SCAN_STRIDE_RST,
                 rsm_pkg::FRAME_ADVANCE_RST, 6'd0);
        send_request(frame_item());
        // Budget above the plane count, zero stride, head frozen.
        set_regs(rsm_pkg::DISABLED_LINE_RST, 5'd0, 5'd0, 6'd63);
        send_request(frame_item());
        // Line 0 hides entry 0 and shows the never-loaded entries.
        set_regs(8'd0, 5'd31, 5'd31, rsm_pkg::PLANE_BUDGET_RST);
        send_request(frame_item());
        send_request(frame_item());
        // Odd budget against a two-plane sprite, line at its top value.
        set_regs(8'd255, 5'd1, 5'd0, 6'd3);
        send_request(frame_item());

        // Random phases, each with its own register setting.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_regs(rsm_pkg::DISABLED_LINE_RST, rsm_pkg::SCAN_STRIDE_RST,
                            rsm_pkg::FRAME_ADVANCE_RST, rsm_pkg::PLANE_BUDGET_RST);
                1: set_regs(8'($urandom_range(0, 255)), 5'd1, 5'd31, 6'd32);
                2: set_regs(8'($urandom_range(0, 255)), 5'd31, 5'd0, 6'd63);
                3: set_regs(8'($urandom_range(0, 255)), 5'd0, 5'd1, 6'd2);
                default: set_regs(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                                  5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
            endcase
            // phase 2: back-to-back requests against the long hold-off
            // phase 4: no idling anywhere
            sender_quiet   = (ph == 2 || ph == 4);
            receiver_quiet = (ph == 4);
            hold_req       = (ph == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(($urandom_range(0, 99) < 30) ? frame_item() : random_load());
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;

        settle();
        if (fail_total == 0 && planes_waiting == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
